// ===== sv/olmpp_pkg.sv =====
// olmpp_pkg: shared constants, types and helper functions of the peak picker
// no dependencies; used by every other file of the block

package olmpp_pkg;

    // sizing (WINDOW and CHANNELS are powers of two, ring positions wrap naturally)
    localparam int CHANNELS   = 16;
    localparam int WINDOW     = 64;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int POS_W      = $clog2(WINDOW);
    localparam int ADDR_W     = CH_W + POS_W;
    localparam int DEPTH      = CHANNELS * WINDOW;
    localparam int SAMPLE_W   = 16;
    localparam int LOOK_W     = 6;
    localparam int HLEN_W     = 7;
    localparam int KCNT_W     = POS_W + 1;

    // configuration port
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int LOOK_RST   = 10;
    localparam int HLEN_RST   = 63;

    typedef enum logic
    {
        REG_LOOKAHEAD   = 1'b0,
        REG_HISTORY_LEN = 1'b1
    } reg_idx_t;

    typedef logic [CH_W-1:0]            chan_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        mag_t;
    typedef logic [LOOK_W-1:0]          look_t;
    typedef logic [HLEN_W-1:0]          hlen_t;
    typedef logic [KCNT_W-1:0]          kcnt_t;

    // one history slot: candidate flag and raw sample
    typedef struct packed
    {
        logic    flag;
        sample_t smp;
    } entry_t;

    // controller to datapath
    typedef struct packed
    {
        logic clear_step;
        logic load;
        logic write_new;
        logic read_chk;
        logic check;
        logic scan_start;
        logic scan_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic clear_last;
        logic rescan;
        logic scan_empty;
        logic scan_last;
        logic out_free;
    } stat_t;

    // exact magnitude of a Q1.15 sample, -1.0 maps to 0x8000
    function automatic mag_t magnitude(input sample_t raw);
        mag_t m;
        begin
            m = raw[SAMPLE_W-1] ? mag_t'(~raw + sample_t'(1)) : mag_t'(raw);
            return m;
        end
    endfunction

endpackage

// ===== sv/olmpp_if.sv =====
// olmpp_if: valid/ready channel interfaces for sample and decision beats
// depends on olmpp_pkg

interface olmpp_in_if;
    logic                 valid;
    logic                 ready;
    olmpp_pkg::chan_t     channel;
    olmpp_pkg::sample_t   sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface olmpp_out_if;
    logic                 valid;
    logic                 ready;
    olmpp_pkg::chan_t     out_channel;
    logic                 spike_decided;
    logic                 new_candidate;

    modport source (output valid, output out_channel, output spike_decided,
                    output new_candidate, input ready);
    modport sink   (input valid, input out_channel, input spike_decided,
                    input new_candidate, output ready);
endinterface

// ===== sv/olmpp_regs.sv =====
// olmpp_regs: apb-style register file holding lookahead and history_len
// depends on olmpp_pkg

module olmpp_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [olmpp_pkg::APB_AW-1:0]   paddr,
    input  logic [olmpp_pkg::APB_DW-1:0]   pwdata,
    output logic [olmpp_pkg::APB_DW-1:0]   prdata,
    output olmpp_pkg::look_t               lookahead,
    output olmpp_pkg::hlen_t               history_len
);

    olmpp_pkg::look_t    lookahead_reg;
    olmpp_pkg::hlen_t    history_len_reg;
    olmpp_pkg::reg_idx_t idx;
    logic                wr_en;

    assign idx   = olmpp_pkg::reg_idx_t'(paddr[2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg   <= olmpp_pkg::look_t'(olmpp_pkg::LOOK_RST);
            history_len_reg <= olmpp_pkg::hlen_t'(olmpp_pkg::HLEN_RST);
        end
        else if (wr_en)
        begin
            unique case (idx)
                olmpp_pkg::REG_LOOKAHEAD:
                    lookahead_reg <= pwdata[olmpp_pkg::LOOK_W-1:0];
                olmpp_pkg::REG_HISTORY_LEN:
                    history_len_reg <= pwdata[olmpp_pkg::HLEN_W-1:0];
                default:
                    lookahead_reg <= lookahead_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            olmpp_pkg::REG_LOOKAHEAD:
                prdata = olmpp_pkg::APB_DW'(lookahead_reg);
            olmpp_pkg::REG_HISTORY_LEN:
                prdata = olmpp_pkg::APB_DW'(history_len_reg);
            default:
                prdata = '0;
        endcase
    end

    assign lookahead   = lookahead_reg;
    assign history_len = history_len_reg;

endmodule

// ===== sv/olmpp_ctrl.sv =====
// olmpp_ctrl: sequencer that steps one sample beat through the datapath
// depends on olmpp_pkg

module olmpp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  olmpp_pkg::stat_t st,
    output olmpp_pkg::cmd_t  cmd
);

    typedef enum logic [7:0]
    {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_WRITE    = 8'b0000_0100,
        ST_RDCHK    = 8'b0000_1000,
        ST_CHECK    = 8'b0001_0000,
        ST_SCAN     = 8'b0010_0000,
        ST_SCAN_END = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = ST_RDCHK;
            end
            ST_RDCHK:
            begin
                cmd.read_chk = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.rescan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = st.scan_empty ? ST_SCAN_END : ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/olmpp_dp.sv =====
// olmpp_dp: history memory, per-channel maximum and ring pointer, scan unit,
// output register; depends on olmpp_pkg

module olmpp_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  olmpp_pkg::cmd_t      cmd,
    output olmpp_pkg::stat_t     st,
    input  olmpp_pkg::look_t     lookahead,
    input  olmpp_pkg::hlen_t     history_len,
    input  olmpp_pkg::chan_t     channel,
    input  olmpp_pkg::sample_t   sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output olmpp_pkg::chan_t     out_channel,
    output logic                 spike_decided,
    output logic                 new_candidate
);

    // history memory: flag and sample per ring slot, channel-major
    olmpp_pkg::entry_t   mem [olmpp_pkg::DEPTH];
    olmpp_pkg::entry_t   rdata_reg;
    logic                mem_we;
    olmpp_pkg::addr_t    mem_waddr;
    olmpp_pkg::entry_t   mem_wdata;
    logic                mem_re;
    olmpp_pkg::addr_t    mem_raddr;

    // per-channel state
    olmpp_pkg::mag_t     tmax_reg [olmpp_pkg::CHANNELS];
    olmpp_pkg::pos_t     wp_reg [olmpp_pkg::CHANNELS];

    // working registers of the item in flight
    olmpp_pkg::addr_t    clr_reg;
    olmpp_pkg::chan_t    ch_reg;
    olmpp_pkg::sample_t  raw_reg;
    olmpp_pkg::mag_t     mag_reg;
    olmpp_pkg::pos_t     pos_reg;
    olmpp_pkg::mag_t     tm_reg;
    logic                newc_reg;
    logic                decided_reg;
    logic                rescan_reg;
    olmpp_pkg::kcnt_t    k_reg;
    olmpp_pkg::mag_t     m_reg;
    logic                scan_vld_reg;

    // output register
    logic                out_valid_reg;
    olmpp_pkg::chan_t    out_channel_reg;
    logic                spike_decided_reg;
    logic                new_candidate_reg;

    olmpp_pkg::pos_t     chk_pos;
    olmpp_pkg::pos_t     scan_pos;
    olmpp_pkg::kcnt_t    scan_len;
    olmpp_pkg::mag_t     rd_mag;
    logic                newc;
    logic                chk_clear;

    assign chk_pos  = pos_reg - olmpp_pkg::pos_t'(lookahead);
    assign scan_pos = pos_reg - k_reg[olmpp_pkg::POS_W-1:0];
    assign scan_len = (history_len > olmpp_pkg::hlen_t'(olmpp_pkg::WINDOW))
                    ? olmpp_pkg::kcnt_t'(olmpp_pkg::WINDOW)
                    : olmpp_pkg::kcnt_t'(history_len);
    assign rd_mag    = olmpp_pkg::magnitude(rdata_reg.smp);
    assign newc      = mag_reg > tm_reg;
    assign chk_clear = rdata_reg.flag && (rd_mag < tm_reg);

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        priority if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.write_new)
        begin
            mem_we         = 1'b1;
            mem_waddr      = {ch_reg, pos_reg};
            mem_wdata.flag = newc;
            mem_wdata.smp  = raw_reg;
        end
        else if (cmd.check && chk_clear)
        begin
            mem_we         = 1'b1;
            mem_waddr      = {ch_reg, chk_pos};
            mem_wdata.flag = 1'b0;
            mem_wdata.smp  = rdata_reg.smp;
        end
    end

    assign mem_re    = cmd.read_chk || cmd.scan_step;
    assign mem_raddr = cmd.read_chk ? {ch_reg, chk_pos} : {ch_reg, scan_pos};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            scan_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < olmpp_pkg::CHANNELS; i++)
            begin
                tmax_reg[i] <= '0;
                wp_reg[i]   <= '0;
            end
        end
        else
        begin
            scan_vld_reg <= cmd.scan_step;
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + olmpp_pkg::addr_t'(1);
            end
            if (cmd.finish)
            begin
                tmax_reg[ch_reg] <= rescan_reg ? m_reg : tm_reg;
                wp_reg[ch_reg]   <= pos_reg + olmpp_pkg::pos_t'(1);
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg  <= channel;
            raw_reg <= sample;
            mag_reg <= olmpp_pkg::magnitude(sample);
            pos_reg <= wp_reg[channel];
            tm_reg  <= tmax_reg[channel];
        end
        if (cmd.write_new)
        begin
            newc_reg <= newc;
            if (newc)
            begin
                tm_reg <= mag_reg;
            end
        end
        if (cmd.check)
        begin
            decided_reg <= rdata_reg.flag && !chk_clear;
            rescan_reg  <= (mag_reg == tm_reg);
        end
        // running maximum, one slot per cycle
        if (cmd.scan_start)
        begin
            k_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                k_reg <= k_reg + olmpp_pkg::kcnt_t'(1);
            end
            if (scan_vld_reg && (rd_mag > m_reg))
            begin
                m_reg <= rd_mag;
            end
        end
        if (cmd.finish)
        begin
            out_channel_reg   <= ch_reg;
            spike_decided_reg <= decided_reg;
            new_candidate_reg <= newc_reg;
        end
    end

    assign st.clear_last = (clr_reg == olmpp_pkg::addr_t'(olmpp_pkg::DEPTH - 1));
    assign st.rescan     = (mag_reg == tm_reg);
    assign st.scan_empty = (scan_len == '0);
    assign st.scan_last  = (k_reg == scan_len - olmpp_pkg::kcnt_t'(1));
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign spike_decided = spike_decided_reg;
    assign new_candidate = new_candidate_reg;

endmodule

// ===== sv/online_local_max_peak_picker.sv =====
// online_local_max_peak_picker: top level of the per-channel peak picker
// depends on olmpp_pkg, olmpp_if, olmpp_regs, olmpp_ctrl, olmpp_dp
//
//  channel    | dir | handshake           | beat contents
//  -----------+-----+---------------------+-----------------------------------------
//  samples    | in  | valid / ready       | channel, sample (signed q1.15)
//  decisions  | out | valid / ready       | out_channel, spike_decided, new_candidate
//  apb        | in  | psel/penable/pready | lookahead @ 0x0, history_len @ 0x4
//
//  one sample beat at a time: accept, slot write, check-slot read, check,
//  then a result step that hands the beat's decision to the output register
//  a magnitude at or above the tracked maximum adds a rescan of min(history_len, 64)
//  history slots, which reads one slot per cycle through the single read port
//  after reset all 1024 history slots are cleared while samples.ready stays low
//  a stalled decision beat holds in the output register; the next sample is still
//  accepted and its result waits in the last step until the register frees

module online_local_max_peak_picker
(
    input  logic                           clk,
    input  logic                           rst_n,
    olmpp_in_if.sink                       samples,
    olmpp_out_if.source                    decisions,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [olmpp_pkg::APB_AW-1:0]   paddr,
    input  logic [olmpp_pkg::APB_DW-1:0]   pwdata,
    output logic [olmpp_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);

    olmpp_pkg::look_t lookahead;
    olmpp_pkg::hlen_t history_len;
    olmpp_pkg::cmd_t  cmd;
    olmpp_pkg::stat_t st;

    // writes complete in the access cycle, no wait states
    assign pready = 1'b1;

    olmpp_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .lookahead   (lookahead),
        .history_len (history_len)
    );

    // sequencer: clear pass, then one sample beat at a time
    olmpp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // history memory, tracked maxima, ring pointers, rescan unit, output register
    olmpp_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .lookahead     (lookahead),
        .history_len   (history_len),
        .channel       (samples.channel),
        .sample        (samples.sample),
        .out_valid     (decisions.valid),
        .out_ready     (decisions.ready),
        .out_channel   (decisions.out_channel),
        .spike_decided (decisions.spike_decided),
        .new_candidate (decisions.new_candidate)
    );

endmodule

// ===== sv/olmpp_checker.sv =====
// olmpp_checker: port-level assertions for the peak picker, bound to the top
// depends on olmpp_pkg and online_local_max_peak_picker

module olmpp_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input olmpp_pkg::chan_t               out_channel,
    input logic                           spike_decided,
    input logic                           new_candidate,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic                           pready,
    input logic [olmpp_pkg::APB_AW-1:0]   paddr,
    input logic [olmpp_pkg::APB_DW-1:0]   pwdata,
    input logic [olmpp_pkg::APB_DW-1:0]   prdata
);

    // one sample in flight: an accepted beat closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted in the cycle after an accept");

    // a fresh decision is launched from the result step, never while input is open
    a_launch_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("decision launched while input was open");

    // stalled decision beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_channel) && $stable(spike_decided)
             && $stable(new_candidate)))
        else $error("decision beat changed while stalled");

    // lookahead read back right after its write
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            ##1 (psel && !pwrite && (paddr[2] == 1'b0))
        |-> (prdata == olmpp_pkg::APB_DW'($past(pwdata[olmpp_pkg::LOOK_W-1:0]))))
        else $error("lookahead read back differs from written value");

endmodule

bind online_local_max_peak_picker olmpp_checker u_olmpp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (decisions.valid),
    .out_ready     (decisions.ready),
    .out_channel   (decisions.out_channel),
    .spike_decided (decisions.spike_decided),
    .new_candidate (decisions.new_candidate),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

// ===== sim/tb_online_local_max_peak_picker.sv =====
// tb_online_local_max_peak_picker: self-checking testbench of the per-channel peak picker
// drives sample beats and apb register writes, checks every decision beat in order
// depends on olmpp_pkg, olmpp_if and the online_local_max_peak_picker rtl

`timescale 1ns / 100ps

module tb_online_local_max_peak_picker;

    // rescan of a full ring plus the fixed steps of one beat, with margin
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_GUARD   = 20000;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 172;
    localparam int DIRECTED      = 22;
    localparam int MAX_REPORTS   = 10;

    // one expected decision beat
    typedef struct packed
    {
        olmpp_pkg::chan_t chan;
        logic             decided;
        logic             fresh;
    } decision_t;

    // per-channel peak tracking, kept in step with the accepted sample beats
    class decision_scoreboard;
        olmpp_pkg::sample_t ring [olmpp_pkg::CHANNELS][olmpp_pkg::WINDOW];
        bit                 cand [olmpp_pkg::CHANNELS][olmpp_pkg::WINDOW];
        int unsigned        peak [olmpp_pkg::CHANNELS];
        olmpp_pkg::pos_t    wr_pos [olmpp_pkg::CHANNELS];
        olmpp_pkg::look_t   look;
        olmpp_pkg::hlen_t   hlen;
        decision_t          due_q [$];
        int unsigned        fails;

        function new();
            for (int c = 0; c < olmpp_pkg::CHANNELS; c++)
            begin
                peak[c]   = 0;
                wr_pos[c] = '0;
                for (int p = 0; p < olmpp_pkg::WINDOW; p++)
                begin
                    ring[c][p] = '0;
                    cand[c][p] = 1'b0;
                end
            end
            look  = olmpp_pkg::look_t'(olmpp_pkg::LOOK_RST);
            hlen  = olmpp_pkg::hlen_t'(olmpp_pkg::HLEN_RST);
            fails = 0;
        endfunction

        static function int unsigned level(olmpp_pkg::sample_t s);
            return (s < 0) ? -int'(s) : int'(s);
        endfunction

        function void set_reg(olmpp_pkg::reg_idx_t r, logic [olmpp_pkg::APB_DW-1:0] v);
            case (r)
                olmpp_pkg::REG_LOOKAHEAD:   look = v[olmpp_pkg::LOOK_W-1:0];
                olmpp_pkg::REG_HISTORY_LEN: hlen = v[olmpp_pkg::HLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // sample accepted: advance the channel and queue its decision
        function void note_sample(olmpp_pkg::chan_t ch, olmpp_pkg::sample_t s);
            olmpp_pkg::pos_t pos;
            olmpp_pkg::pos_t chk;
            int unsigned     lvl;
            int unsigned     span;
            int unsigned     best;
            decision_t       d;
            pos = wr_pos[ch];
            lvl = level(s);
            ring[ch][pos] = s;
            d.fresh = (lvl > peak[ch]);
            if (d.fresh)
                peak[ch] = lvl;
            cand[ch][pos] = d.fresh;
            // ring wraps at 64, so the lookahead distance folds in naturally
            chk = pos - olmpp_pkg::pos_t'(look);
            if (cand[ch][chk] && level(ring[ch][chk]) < peak[ch])
                cand[ch][chk] = 1'b0;
            d.decided = cand[ch][chk];
            if (lvl == peak[ch])
            begin
                span = (hlen > olmpp_pkg::WINDOW) ? olmpp_pkg::WINDOW : hlen;
                best = 0;
                for (int k = 0; k < span; k++)
                    if (level(ring[ch][pos - olmpp_pkg::pos_t'(k)]) > best)
                        best = level(ring[ch][pos - olmpp_pkg::pos_t'(k)]);
                peak[ch] = best;
            end
            wr_pos[ch] = pos + olmpp_pkg::pos_t'(1);
            d.chan = ch;
            due_q.push_back(d);
        endfunction

        function void flag_error(string what, decision_t want, decision_t got);
            fails++;
            if (fails <= MAX_REPORTS)
                $display({"mismatch (%s): expected ch %0d spike %0b cand %0b, ",
                          "got ch %0d spike %0b cand %0b"},
                         what, want.chan, want.decided, want.fresh,
                         got.chan, got.decided, got.fresh);
        endfunction

        // decision beat accepted: compare with the oldest expectation
        function void check_decision(olmpp_pkg::chan_t ch, logic spike, logic fresh);
            decision_t got;
            decision_t want;
            got.chan    = ch;
            got.decided = spike;
            got.fresh   = fresh;
            if (due_q.size() == 0)
            begin
                want = '0;
                flag_error("no decision outstanding", want, got);
                return;
            end
            want = due_q.pop_front();
            if (got.chan !== want.chan || got.decided !== want.decided ||
                got.fresh !== want.fresh)
                flag_error("field", want, got);
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [olmpp_pkg::APB_AW-1:0]   paddr;
    logic [olmpp_pkg::APB_DW-1:0]   pwdata;
    logic [olmpp_pkg::APB_DW-1:0]   prdata;
    logic                           pready;

    olmpp_in_if  samples ();
    olmpp_out_if decisions ();

    decision_scoreboard sb;

    // idling percentages of the current phase, only changed while drained
    int tx_idle_pct;
    int rx_stall_pct;

    // directed opening: extremes, ties that force a rescan, a held candidate
    int directed_ch  [DIRECTED] = '{0, 0, 0, 0, 0, 0, 0, 15, 15, 15, 15, 15,
                                    0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    int directed_smp [DIRECTED] = '{0, 1, -1, 32767, -32768, 100, -32768,
                                    -32767, 32767, -2, 21845, -21846,
                                    3, -7, 0, 12, -40, 255, -256, 1024, -3, 9};

    // lookahead / history_len per phase; the -1 entries are drawn at random
    int phase_look [PHASES] = '{10, 0, 63, 1, 32, 5, -1, 63};
    int phase_hlen [PHASES] = '{63, 0, 64, 1, 127, 100, -1, 65};

    online_local_max_peak_picker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples.sink),
        .decisions (decisions.source),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // apb write: setup cycle, then access until pready, register updates on that edge
    task automatic write_reg(olmpp_pkg::reg_idx_t r, logic [olmpp_pkg::APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
        // the bus idles with psel low before the next transfer
        @(posedge clk);
    endtask

    // one sample beat; valid is left high so back-to-back beats never toggle it
    // within a step, the caller lowers it once the burst is over
    task automatic send_sample(olmpp_pkg::chan_t ch, olmpp_pkg::sample_t s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid   <= 1'b1;
        samples.channel <= ch;
        samples.sample  <= s;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        sb.note_sample(ch, s);
    endtask

    // wait until every decision is checked or the drain guard runs out, then idle for SETTLE_CYCLES
    task automatic settle();
        int guard;
        guard = 0;
        while (sb.outstanding() > 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pulse-train-like content: low noise in 45 of 100 draws, spikes, extremes, random words, plus exact ties
    // with the tracked maximum so the rescan path gets plenty of traffic
    function automatic olmpp_pkg::sample_t pick_sample(olmpp_pkg::chan_t ch);
        int          r;
        int unsigned lvl;
        bit          neg;
        r   = $urandom_range(99);
        neg = 1'($urandom_range(1));
        if (r < 45)
            return olmpp_pkg::sample_t'(int'($urandom_range(400)) - 200);
        if (r < 65)
            lvl = $urandom_range(32767, 1000);
        else if (r < 80)
            lvl = sb.peak[ch];
        else if (r < 88)
        begin
            case ($urandom_range(3))
                0:       lvl = 32768;
                1:       lvl = 32767;
                2:       lvl = 0;
                default: lvl = 1;
            endcase
        end
        else
            return olmpp_pkg::sample_t'($urandom);
        return olmpp_pkg::sample_t'(neg ? -int'(lvl) : int'(lvl));
    endfunction

    // decision side: check on every accepted beat, then choose next ready
    initial
    begin
        decisions.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (decisions.valid === 1'b1 && decisions.ready === 1'b1)
                sb.check_decision(decisions.out_channel, decisions.spike_decided,
                                  decisions.new_candidate);
            decisions.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // main sequence
    initial
    begin
        int               base;
        olmpp_pkg::chan_t ch;
        int               look_v;
        int               hlen_v;
        sb              = new();
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        samples.valid   = 1'b0;
        samples.channel = '0;
        samples.sample  = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at the reset settings; ready stays low during the clearing pass
        for (int i = 0; i < DIRECTED; i++)
            send_sample(olmpp_pkg::chan_t'(directed_ch[i]),
                        olmpp_pkg::sample_t'(directed_smp[i]));
        samples.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            look_v = (phase_look[p] < 0) ? int'($urandom_range(63)) : phase_look[p];
            hlen_v = (phase_hlen[p] < 0) ? int'($urandom_range(127)) : phase_hlen[p];
            write_reg(olmpp_pkg::REG_LOOKAHEAD, look_v);
            write_reg(olmpp_pkg::REG_HISTORY_LEN, hlen_v);

            // idling modes rotate: none, sender gaps, receiver stalls, both light
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 57; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 57; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase

            // a few channels per phase so rings wrap and candidates mature
            base = $urandom_range(12);
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if ($urandom_range(99) < 90)
                    ch = olmpp_pkg::chan_t'(base + int'($urandom_range(3)));
                else
                    ch = olmpp_pkg::chan_t'($urandom_range(15));
                send_sample(ch, pick_sample(ch));
            end
            samples.valid <= 1'b0;
        end

        settle();
        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
